### hw/rtl/crl_pkg.sv
// ----------------------------------------------------------------------------
// crl_pkg
// Shared widths, types and codes for the LRU/MRU/LFU replacement cache.
// ----------------------------------------------------------------------------
package crl_pkg;

  // Built number of entries (cells in the recency row)
  localparam int WAYS  = 16;

  localparam int KEY_W = 32;
  localparam int CNT_W = 16;
  localparam int POL_W = 2;
  localparam int CAP_W = 5;
  localparam int OCC_W = $clog2(WAYS + 1);

  // Stream payload widths, padded to whole bytes
  localparam int IN_W  = 40;
  localparam int OUT_W = 40;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [WAYS-1:0][KEY_W-1:0] key_arr_t;
  typedef logic [WAYS-1:0][CNT_W-1:0] cnt_arr_t;

  // Replacement policy carried with each access
  typedef enum logic [POL_W-1:0] {
    POL_LRU = 2'd0,
    POL_MRU = 2'd1,
    POL_LFU = 2'd2,
    POL_BAD = 2'd3
  } policy_e;

  // Register index (byte address bit 2)
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam cnt_t CNT_MAX = '1;
  localparam cnt_t CNT_ONE = 16'd1;

  // Per-cell update control
  typedef struct packed {
    logic load;   // take the new key/count
    logic shift;  // take the neighbor's key/count
  } cell_ctrl_t;

endpackage

### hw/rtl/crl_cell.sv
// ----------------------------------------------------------------------------
// crl_cell
// One position of the recency row: holds a key and its use count, compares
// the key against the access key, and loads either a new entry or the entry
// of the next more recent neighbor.
// ----------------------------------------------------------------------------
module crl_cell (
  input  logic                 clk_i,
  input  crl_pkg::cell_ctrl_t  ctrl_i,
  input  crl_pkg::key_t        probe_key_i,
  input  crl_pkg::key_t        new_key_i,
  input  crl_pkg::cnt_t        new_cnt_i,
  input  crl_pkg::key_t        nbr_key_i,
  input  crl_pkg::cnt_t        nbr_cnt_i,
  output crl_pkg::key_t        key_o,
  output crl_pkg::cnt_t        cnt_o,
  output logic                 match_o
);
  import crl_pkg::*;

  key_t key_q, key_d;
  cnt_t cnt_q, cnt_d;

  // next entry: load wins over shift
  always_comb begin
    key_d = key_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      key_d = new_key_i;
      cnt_d = new_cnt_i;
    end else if (ctrl_i.shift) begin
      key_d = nbr_key_i;
      cnt_d = nbr_cnt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cnt_q <= cnt_d;
  end

  assign key_o   = key_q;
  assign cnt_o   = cnt_q;
  assign match_o = (key_q == probe_key_i);

endmodule

### hw/rtl/crl_lfu_pick.sv
// ----------------------------------------------------------------------------
// crl_lfu_pick
// Least-count victim select over the recency row. All pairs of counts are
// compared in parallel; a position wins when its count is below every less
// recent count and not above any more recent count, so ties go to the
// least recent entry. Output is one-hot over valid positions.
// ----------------------------------------------------------------------------
module crl_lfu_pick (
  input  crl_pkg::cnt_arr_t      cnt_i,
  input  logic [crl_pkg::WAYS-1:0] valid_i,
  output logic [crl_pkg::WAYS-1:0] sel_o
);
  import crl_pkg::*;

  always_comb begin
    for (int p = 0; p < WAYS; p++) begin
      sel_o[p] = valid_i[p];
      for (int q = 0; q < WAYS; q++) begin
        if (valid_i[q]) begin
          if (q < p) begin
            sel_o[p] = sel_o[p] & (cnt_i[p] < cnt_i[q]);
          end else if (q > p) begin
            sel_o[p] = sel_o[p] & (cnt_i[p] <= cnt_i[q]);
          end
        end
      end
    end
  end

endmodule

### hw/rtl/cache_replacement_lru_mru_lfu.sv
// ----------------------------------------------------------------------------
// cache_replacement_lru_mru_lfu
// Fully associative key cache with per-access LRU, MRU or LFU replacement.
// Entries sit in a row of cells ordered by recency (position 0 least recent).
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake           Payload
// s_axis    in   tvalid/tready       tdata: key, policy
// m_axis    out  tvalid/tready       tdata: hit, evicted_valid, evicted_key,
//                                           policy_error, occupancy
// apb       in   psel/penable/pready capacity register at byte address 0
//
// An access first captures the beat in the input register; a compare/update
// pass then compares the key in every cell, picks the victim and updates the
// cell row. The input register takes no new beat until its own has executed.
// A new beat is taken while the previous result waits in the output register;
// the update stalls only while the output register is full and not taken.
// Reset clears the valid count and restores capacity to 16; keys and counts
// need no clearing, since only positions below the valid count are read.
//
module cache_replacement_lru_mru_lfu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // access stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [crl_pkg::IN_W-1:0]   s_axis_tdata,   // [31:0] key, [33:32] policy,
                                                     // [39:34] zero
  // result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [crl_pkg::OUT_W-1:0]  m_axis_tdata,   // [0] hit, [1] evicted_valid,
                                                     // [33:2] evicted_key,
                                                     // [34] policy_error, [39:35] occupancy
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import crl_pkg::*;

  // control and payload registers
  logic                 in_valid_q;
  key_t                 in_key_q;
  policy_e              in_pol_q;
  logic                 out_valid_q;
  logic [OUT_W-1:0]     out_data_q, out_data_d;
  logic [OCC_W-1:0]     vc_q, vc_d;
  logic [CAP_W-1:0]     cap_q;

  logic                 exec;
  logic                 cfg_wr;

  key_arr_t             cell_key;
  cnt_arr_t             cell_cnt;
  logic [WAYS-1:0]      match;
  logic [WAYS-1:0]      valid;
  logic [WAYS-1:0]      hitv;
  logic [WAYS-1:0]      lfu_sel;
  logic [WAYS-1:0]      mru_sel;
  logic [WAYS-1:0]      sel;
  logic [WAYS-1:0]      ge_sel;
  cell_ctrl_t [WAYS-1:0] ctrl;

  logic                 hit;
  logic                 full;
  logic                 do_remove;
  logic                 do_load;
  logic                 evict;
  logic                 perr;
  logic [OCC_W-1:0]     dst;
  cnt_t                 hit_cnt;
  cnt_t                 new_cnt;
  key_t                 ev_key;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // ---------------- input register ----------------
  assign s_axis_tready = !in_valid_q;
  assign exec          = in_valid_q && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (exec) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_key_q <= s_axis_tdata[KEY_W-1:0];
      in_pol_q <= policy_e'(s_axis_tdata[KEY_W+POL_W-1:KEY_W]);
    end
  end

  // ---------------- cell row ----------------
  for (genvar p = 0; p < WAYS; p++) begin : g_cell
    key_t nbr_key;
    cnt_t nbr_cnt;
    if (p < WAYS - 1) begin : g_nbr
      assign nbr_key = cell_key[p+1];
      assign nbr_cnt = cell_cnt[p+1];
    end else begin : g_end
      assign nbr_key = '0;
      assign nbr_cnt = '0;
    end

    crl_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl[p]),
      .probe_key_i (in_key_q),
      .new_key_i   (in_key_q),
      .new_cnt_i   (new_cnt),
      .nbr_key_i   (nbr_key),
      .nbr_cnt_i   (nbr_cnt),
      .key_o       (cell_key[p]),
      .cnt_o       (cell_cnt[p]),
      .match_o     (match[p])
    );

    assign valid[p]   = (OCC_W'(p) < vc_q);
    assign hitv[p]    = match[p] & valid[p];
    assign mru_sel[p] = (OCC_W'(p) == vc_q - OCC_W'(1));
  end

  crl_lfu_pick u_lfu (
    .cnt_i   (cell_cnt),
    .valid_i (valid),
    .sel_o   (lfu_sel)
  );

  assign hit = |hitv;

  // count of the hit entry
  always_comb begin
    hit_cnt = '0;
    for (int p = 0; p < WAYS; p++) begin
      hit_cnt = hit_cnt | (hitv[p] ? cell_cnt[p] : '0);
    end
  end

  // capacity in use is clamped to 1..WAYS
  always_comb begin
    if (cap_q == '0) begin
      full = (vc_q != '0);
    end else if (32'(cap_q) >= WAYS) begin
      full = (32'(vc_q) >= WAYS);
    end else begin
      full = (32'(vc_q) >= 32'(cap_q));
    end
  end

  // access decision
  always_comb begin
    sel       = '0;
    do_remove = 1'b0;
    do_load   = 1'b0;
    evict     = 1'b0;
    perr      = 1'b0;
    dst       = vc_q - OCC_W'(1);
    new_cnt   = CNT_ONE;
    vc_d      = vc_q;
    if (hit) begin
      sel       = hitv;
      do_remove = 1'b1;
      do_load   = 1'b1;
      new_cnt   = (hit_cnt == CNT_MAX) ? hit_cnt : hit_cnt + CNT_ONE;
    end else if (!full) begin
      do_load = 1'b1;
      dst     = vc_q;
      vc_d    = vc_q + OCC_W'(1);
    end else begin
      case (in_pol_q)
        POL_LRU: begin
          sel       = WAYS'(1);
          do_remove = 1'b1;
          do_load   = 1'b1;
          evict     = 1'b1;
        end
        POL_MRU: begin
          sel     = mru_sel;
          do_load = 1'b1;
          evict   = 1'b1;
        end
        POL_LFU: begin
          sel       = lfu_sel;
          do_remove = 1'b1;
          do_load   = 1'b1;
          evict     = 1'b1;
        end
        POL_BAD: begin
          perr = 1'b1;
        end
        default: begin
          perr = 1'b1;
        end
      endcase
    end
  end

  // positions at or above the removed entry slide down toward it
  always_comb begin
    for (int p = 0; p < WAYS; p++) begin
      ge_sel[p] = 1'b0;
      for (int q = 0; q <= p; q++) begin
        ge_sel[p] = ge_sel[p] | sel[q];
      end
    end
  end

  always_comb begin
    for (int p = 0; p < WAYS; p++) begin
      ctrl[p].shift = exec && do_remove && ge_sel[p] && (OCC_W'(p) < dst);
      ctrl[p].load  = exec && do_load && (OCC_W'(p) == dst);
    end
  end

  // evicted key from the selected position
  always_comb begin
    ev_key = '0;
    for (int p = 0; p < WAYS; p++) begin
      ev_key = ev_key | (sel[p] ? cell_key[p] : '0);
    end
    if (!evict) begin
      ev_key = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= '0;
    end else if (exec) begin
      vc_q <= vc_d;
    end
  end

  // ---------------- output register ----------------
  assign out_data_d = {5'(vc_d), perr, ev_key, evict, hit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
